/* rtl/kstb_pkg.sv */
// ---------------------------------------------------------------------------
// kstb_pkg
// Shared types and codes of the keyed software timer bank.
// ---------------------------------------------------------------------------
package kstb_pkg;

   localparam int DefaultTimerSlots = 16;
   localparam logic [9:0] TickLenReset = 10'd10;

   localparam logic [1:0] ACT_TICK   = 2'd0;
   localparam logic [1:0] ACT_SET    = 2'd1;
   localparam logic [1:0] ACT_KILL   = 2'd2;
   localparam logic [1:0] ACT_CLIENT = 2'd3;

   localparam logic [1:0] STS_DONE   = 2'd0;
   localparam logic [1:0] STS_FULL   = 2'd1;
   localparam logic [1:0] STS_ABSENT = 2'd2;

   typedef struct packed {
      logic [15:0] client;
      logic [15:0] timer;
      logic [31:0] interval;
      logic [31:0] elapsed;
      logic        one_shot;
   } slot_entry_type;

   typedef struct packed {
      logic load_req;
      logic rd_en;
      logic eval;
      logic finish;
      logic sel_start;
      logic sel_eval;
      logic pick;
   } cmd_type;

   typedef struct packed {
      logic [1:0] action;
      logic       fired_any;
   } sts_type;

endpackage

/* rtl/keyed_software_timer_bank.sv */
// ---------------------------------------------------------------------------
// keyed_software_timer_bank
// Table of keyed timers with set, kill and tick requests.
//
// Channel  Direction  Handshake            Contents
// req      in         req_tvalid/tready    one request
// rsp      out        rsp_tvalid/tready    one result, tlast on the final one
// csr      in         csr_wr_en            tick length in milliseconds
//
// A request sweeps the slots through the single read port of the slot memory
// and then presents its result. A tick that fires timers runs one ordered
// selection sweep per fired timer. Reset is synchronous and clears all slots
// at once. A stalled result holds the block; no request is taken until the
// last result has been delivered.
// ---------------------------------------------------------------------------
module keyed_software_timer_bank #(
   parameter int TIMER_SLOTS = kstb_pkg::DefaultTimerSlots
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [9:0]  csr_wr_data,
   input  logic        req_tvalid,
   output logic        req_tready,
   // client_id, timer_num, interval_ms, one_shot, zero padding
   input  logic [71:0] req_tdata,
   // action
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // status, fired_client, fired_timer, zero padding
   output logic [39:0] rsp_tdata,
   // fired_flag
   output logic [0:0]  rsp_tuser,
   output logic        rsp_tlast
);

   localparam int IdxW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;

   kstb_pkg::cmd_type cmd;
   kstb_pkg::sts_type sts;
   logic [IdxW-1:0]   idx;

   kstb_controller #(.TIMER_SLOTS(TIMER_SLOTS)) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd),
      .idx        (idx)
   );

   kstb_datapath #(.TIMER_SLOTS(TIMER_SLOTS)) u_dp (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .cmd         (cmd),
      .idx         (idx),
      .sts         (sts),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

endmodule

/* rtl/kstb_datapath.sv */
// ---------------------------------------------------------------------------
// kstb_datapath
// Slot memory, slot flags, request and result registers of the timer bank.
// ---------------------------------------------------------------------------
module kstb_datapath #(
   parameter int TIMER_SLOTS = kstb_pkg::DefaultTimerSlots,
   localparam int IdxW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [9:0]        csr_wr_data,
   input  logic [71:0]       req_tdata,
   input  logic [1:0]        req_tuser,
   input  kstb_pkg::cmd_type cmd,
   input  logic [IdxW-1:0]   idx,
   output kstb_pkg::sts_type sts,
   output logic [39:0]       rsp_tdata,
   output logic [0:0]        rsp_tuser,
   output logic              rsp_tlast
);

   kstb_pkg::slot_entry_type mem [TIMER_SLOTS];
   kstb_pkg::slot_entry_type rdata_ff;
   kstb_pkg::slot_entry_type wdata;
   logic                     we;
   logic [IdxW-1:0]          waddr;

   logic [9:0]  tick_len_ff;
   logic [1:0]  act_ff;
   logic [15:0] cl_ff, tm_ff;
   logic [31:0] iv_ff;
   logic        os_ff;

   logic [TIMER_SLOTS-1:0] valid_ff, valid_in, pend_ff, pend_in;
   logic [TIMER_SLOTS-1:0] stop_ff, stop_in, fired_ff, fired_in;
   logic            found_ff, found_in, have_ff, have_in;
   logic [IdxW-1:0] match_ff, match_in, min_idx_ff, min_idx_in;
   logic [31:0]     min_key_ff, min_key_in;

   logic [1:0]  status_ff, status_in;
   logic        flag_ff, flag_in, last_ff, last_in;
   logic [15:0] fcl_ff, fcl_in, ftm_ff, ftm_in;

   logic            key_hit, client_hit, fire, free_any, remove;
   logic [IdxW-1:0] free_idx;
   logic [32:0]     sum;
   logic [31:0]     elapsed_new, sel_key;

   assign client_hit = valid_ff[idx] && (rdata_ff.client == cl_ff);
   assign key_hit = client_hit && (rdata_ff.timer == tm_ff);
   assign sum = {1'b0, rdata_ff.elapsed} + {23'd0, tick_len_ff};
   assign elapsed_new = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
   assign fire = elapsed_new >= rdata_ff.interval;
   assign sel_key = {rdata_ff.client, rdata_ff.timer};

   always_comb begin
      free_any = 1'b0;
      free_idx = '0;
      for (int i = TIMER_SLOTS - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_any = 1'b1;
            free_idx = IdxW'(i);
         end
      end
   end

   always_comb begin
      valid_in = valid_ff;
      pend_in = pend_ff;
      stop_in = stop_ff;
      fired_in = fired_ff;
      found_in = found_ff;
      match_in = match_ff;
      have_in = have_ff;
      min_idx_in = min_idx_ff;
      min_key_in = min_key_ff;
      status_in = status_ff;
      flag_in = flag_ff;
      last_in = last_ff;
      fcl_in = fcl_ff;
      ftm_in = ftm_ff;
      we = 1'b0;
      waddr = idx;
      wdata = rdata_ff;
      remove = 1'b0;
      if (cmd.load_req) begin
         fired_in = '0;
         found_in = 1'b0;
      end
      if (cmd.sel_start) begin
         have_in = 1'b0;
      end
      if (cmd.eval) begin
         unique case (act_ff)
            kstb_pkg::ACT_TICK: begin
               if (valid_ff[idx] && !stop_ff[idx]) begin
                  we = 1'b1;
                  wdata.elapsed = fire ? 32'd0 : elapsed_new;
                  if (fire) begin
                     fired_in[idx] = 1'b1;
                     if (rdata_ff.one_shot) begin
                        pend_in[idx] = 1'b1;
                     end
                  end
               end
            end
            kstb_pkg::ACT_SET: begin
               if (key_hit) begin
                  found_in = 1'b1;
                  match_in = idx;
               end
            end
            kstb_pkg::ACT_KILL: begin
               if (key_hit) begin
                  found_in = 1'b1;
                  pend_in[idx] = 1'b1;
               end
            end
            default: begin
               if (client_hit) begin
                  found_in = 1'b1;
                  pend_in[idx] = 1'b1;
                  stop_in[idx] = 1'b1;
               end
            end
         endcase
      end
      if (cmd.sel_eval) begin
         if (fired_ff[idx] && (!have_ff || (sel_key < min_key_ff))) begin
            have_in = 1'b1;
            min_key_in = sel_key;
            min_idx_in = idx;
         end
      end
      if (cmd.finish) begin
         flag_in = 1'b0;
         last_in = 1'b1;
         fcl_in = '0;
         ftm_in = '0;
         status_in = kstb_pkg::STS_DONE;
         wdata.client = cl_ff;
         wdata.timer = tm_ff;
         wdata.interval = iv_ff;
         wdata.elapsed = '0;
         wdata.one_shot = os_ff;
         unique case (act_ff)
            kstb_pkg::ACT_TICK: begin
               remove = 1'b1;
            end
            kstb_pkg::ACT_SET: begin
               if (found_ff) begin
                  we = 1'b1;
                  waddr = match_ff;
               end else if (free_any) begin
                  we = 1'b1;
                  waddr = free_idx;
                  valid_in[free_idx] = 1'b1;
                  pend_in[free_idx] = 1'b0;
                  stop_in[free_idx] = 1'b0;
               end else begin
                  status_in = kstb_pkg::STS_FULL;
               end
            end
            default: begin
               if (!found_ff) begin
                  status_in = kstb_pkg::STS_ABSENT;
               end
            end
         endcase
      end
      if (cmd.pick) begin
         fired_in[min_idx_in] = 1'b0;
         flag_in = 1'b1;
         status_in = kstb_pkg::STS_DONE;
         fcl_in = min_key_in[31:16];
         ftm_in = min_key_in[15:0];
         last_in = (fired_in == '0);
         remove = last_in;
      end
      if (remove) begin
         valid_in = valid_ff & ~pend_ff;
         stop_in = stop_ff & ~pend_ff;
         pend_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_len_ff <= kstb_pkg::TickLenReset;
         valid_ff <= '0;
         pend_ff <= '0;
         stop_ff <= '0;
         fired_ff <= '0;
         found_ff <= 1'b0;
         have_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            tick_len_ff <= csr_wr_data;
         end
         valid_ff <= valid_in;
         pend_ff <= pend_in;
         stop_ff <= stop_in;
         fired_ff <= fired_in;
         found_ff <= found_in;
         have_ff <= have_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         act_ff <= req_tuser;
         cl_ff <= req_tdata[15:0];
         tm_ff <= req_tdata[31:16];
         iv_ff <= req_tdata[63:32];
         os_ff <= req_tdata[64];
      end
      match_ff <= match_in;
      min_idx_ff <= min_idx_in;
      min_key_ff <= min_key_in;
      status_ff <= status_in;
      flag_ff <= flag_in;
      last_ff <= last_in;
      fcl_ff <= fcl_in;
      ftm_ff <= ftm_in;
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (cmd.rd_en) begin
         rdata_ff <= mem[idx];
      end
   end

   assign sts.action = act_ff;
   assign sts.fired_any = (fired_ff != '0);
   assign rsp_tdata = {6'd0, ftm_ff, fcl_ff, status_ff};
   assign rsp_tuser = flag_ff;
   assign rsp_tlast = last_ff;

endmodule

/* rtl/kstb_controller.sv */
// ---------------------------------------------------------------------------
// kstb_controller
// Sequencer that sweeps the slots for each request and emits the results.
// ---------------------------------------------------------------------------
module kstb_controller #(
   parameter int TIMER_SLOTS = kstb_pkg::DefaultTimerSlots,
   localparam int IdxW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   input  kstb_pkg::sts_type sts,
   output kstb_pkg::cmd_type cmd,
   output logic [IdxW-1:0]   idx
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_RD   = 3'd1;
   localparam logic [2:0] S_EV   = 3'd2;
   localparam logic [2:0] S_FIN  = 3'd3;
   localparam logic [2:0] S_SRD  = 3'd4;
   localparam logic [2:0] S_SEV  = 3'd5;
   localparam logic [2:0] S_OUT  = 3'd6;
   localparam logic [IdxW-1:0] LastIdx = IdxW'(TIMER_SLOTS - 1);

   logic [2:0]      state_ff, state_in;
   logic [IdxW-1:0] idx_ff, idx_in;

   always_comb begin
      state_in = state_ff;
      idx_in = idx_ff;
      cmd = '0;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load_req = 1'b1;
               idx_in = '0;
               state_in = S_RD;
            end
         end
         S_RD: begin
            cmd.rd_en = 1'b1;
            state_in = S_EV;
         end
         S_EV: begin
            cmd.eval = 1'b1;
            if (idx_ff == LastIdx) begin
               state_in = S_FIN;
            end else begin
               idx_in = idx_ff + 1'b1;
               state_in = S_RD;
            end
         end
         S_FIN: begin
            if (sts.action == kstb_pkg::ACT_TICK && sts.fired_any) begin
               cmd.sel_start = 1'b1;
               idx_in = '0;
               state_in = S_SRD;
            end else begin
               cmd.finish = 1'b1;
               state_in = S_OUT;
            end
         end
         S_SRD: begin
            cmd.rd_en = 1'b1;
            state_in = S_SEV;
         end
         S_SEV: begin
            cmd.sel_eval = 1'b1;
            if (idx_ff == LastIdx) begin
               state_in = S_OUT;
            end else begin
               idx_in = idx_ff + 1'b1;
               state_in = S_SRD;
            end
         end
         S_OUT: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               if (sts.fired_any) begin
                  cmd.sel_start = 1'b1;
                  idx_in = '0;
                  state_in = S_SRD;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      if (state_ff == S_SEV && idx_ff == LastIdx) begin
         cmd.pick = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         idx_ff <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff <= idx_in;
      end
   end

   assign idx = idx_ff;

   a_pick_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.pick |=> rsp_tvalid)
      else $error("A picked timer was not presented.");
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && !sts.fired_any) |=> req_tready)
      else $error("The block did not return to idle after its final result.");
   a_one_side: assert property (@(posedge clock) disable iff (reset)
      cmd.load_req |=> !rsp_tvalid && !req_tready)
      else $error("A request was taken while another was still in progress.");

endmodule

/* tb/keyed_software_timer_bank_test.sv */
// ---------------------------------------------------------------------------
// keyed_software_timer_bank_test
// Self-checking bench for the keyed timer bank. Requests go in through the
// req stream. A behavioural copy of the timer table predicts every result,
// and each result on the rsp stream is checked against the oldest
// prediction. Both sides idle at random, and the tick length is changed
// between phases.
// ---------------------------------------------------------------------------
module keyed_software_timer_bank_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int Slots = kstb_pkg::DefaultTimerSlots;

   typedef struct {
      logic [1:0]  status;
      logic        flag;
      logic [15:0] client;
      logic [15:0] timer;
      logic        last;
   } timer_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic [9:0]  csr_wr_data = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [71:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic [0:0]  rsp_tuser;
   logic        rsp_tlast;

   timer_result_type expected_results[$];
   int          errors = 0;
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   int          recv_hold = 0;

   logic [9:0]  tick_len;
   logic        live[Slots];
   logic [15:0] key_client[Slots];
   logic [15:0] key_timer[Slots];
   logic [31:0] interval[Slots];
   logic [31:0] elapsed[Slots];
   logic        one_shot[Slots];
   logic        doomed[Slots];
   logic        halted[Slots];

   keyed_software_timer_bank dut (
      .clock(clock), .reset(reset),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast)
   );

   always #6 clock = ~clock;

   initial begin
      #50ms;
      $display("keyed_software_timer_bank_test NOT OK");
      $finish;
   end

   function automatic int find_key(logic [15:0] cl, logic [15:0] tm);
      for (int i = 0; i < Slots; i++)
         if (live[i] && key_client[i] == cl && key_timer[i] == tm) return i;
      return -1;
   endfunction

   function automatic void push_result(logic [1:0] st, logic fl, logic [15:0] cl,
                                       logic [15:0] tm, logic lst);
      timer_result_type r;
      r.status = st; r.flag = fl; r.client = cl; r.timer = tm; r.last = lst;
      expected_results.insert(expected_results.size(), r);
   endfunction

   function automatic void predict_tick();
      logic fired[Slots];
      logic [32:0] sum;
      int n;
      int best;
      n = 0;
      for (int i = 0; i < Slots; i++) begin
         fired[i] = 1'b0;
         if (live[i] && !halted[i]) begin
            sum = {1'b0, elapsed[i]} + {23'd0, tick_len};
            elapsed[i] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
            if (elapsed[i] >= interval[i]) begin
               elapsed[i] = '0;
               if (one_shot[i]) doomed[i] = 1'b1;
               fired[i] = 1'b1;
               n++;
            end
         end
      end
      for (int k = 0; k < n; k++) begin
         best = -1;
         for (int i = 0; i < Slots; i++)
            if (fired[i] && (best < 0 ||
                {key_client[i], key_timer[i]} < {key_client[best], key_timer[best]}))
               best = i;
         fired[best] = 1'b0;
         push_result(kstb_pkg::STS_DONE, 1'b1, key_client[best], key_timer[best],
                     k == n - 1);
      end
      for (int i = 0; i < Slots; i++)
         if (live[i] && doomed[i]) begin
            live[i] = 1'b0; doomed[i] = 1'b0; halted[i] = 1'b0;
         end
      if (n == 0) push_result(kstb_pkg::STS_DONE, 1'b0, '0, '0, 1'b1);
   endfunction

   function automatic void predict_request(logic [1:0] act, logic [15:0] cl,
                                           logic [15:0] tm, logic [31:0] iv, logic os);
      logic [1:0] st;
      int s;
      st = kstb_pkg::STS_DONE;
      if (act == kstb_pkg::ACT_TICK) begin
         predict_tick();
         return;
      end
      if (act == kstb_pkg::ACT_SET) begin
         s = find_key(cl, tm);
         if (s >= 0) begin
            interval[s] = iv; one_shot[s] = os; elapsed[s] = '0;
         end else begin
            for (int i = 0; i < Slots; i++)
               if (!live[i]) begin
                  s = i;
                  break;
               end
            if (s < 0) st = kstb_pkg::STS_FULL;
            else begin
               live[s] = 1'b1; key_client[s] = cl; key_timer[s] = tm;
               interval[s] = iv; elapsed[s] = '0; one_shot[s] = os;
               doomed[s] = 1'b0; halted[s] = 1'b0;
            end
         end
      end else if (act == kstb_pkg::ACT_KILL) begin
         s = find_key(cl, tm);
         if (s >= 0) doomed[s] = 1'b1;
         else st = kstb_pkg::STS_ABSENT;
      end else begin
         st = kstb_pkg::STS_ABSENT;
         for (int i = 0; i < Slots; i++)
            if (live[i] && key_client[i] == cl) begin
               doomed[i] = 1'b1; halted[i] = 1'b1; st = kstb_pkg::STS_DONE;
            end
      end
      push_result(st, 1'b0, '0, '0, 1'b1);
   endfunction

   always @(posedge clock) begin
      timer_result_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected result tdata=%h tuser=%b tlast=%b",
                     $time, rsp_tdata, rsp_tuser, rsp_tlast);
            errors++;
         end else begin
            e = expected_results.pop_front();
            if (rsp_tdata[1:0] !== e.status || rsp_tuser[0] !== e.flag ||
                rsp_tdata[17:2] !== e.client || rsp_tdata[33:18] !== e.timer ||
                rsp_tdata[39:34] !== '0 || rsp_tlast !== e.last) begin
               $display("%0t: expected st=%0d fl=%b cl=%h tm=%h last=%b",
                        $time, e.status, e.flag, e.client, e.timer, e.last);
               $display("%0t: actual   st=%0d fl=%b cl=%h tm=%h last=%b pad=%h",
                        $time, rsp_tdata[1:0], rsp_tuser[0], rsp_tdata[17:2],
                        rsp_tdata[33:18], rsp_tlast, rsp_tdata[39:34]);
               errors++;
            end
         end
      end
      if (recv_hold > 0) begin
         recv_hold <= recv_hold - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic send_request(logic [1:0] act, logic [15:0] cl, logic [15:0] tm,
                               logic [31:0] iv, logic os);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= act;
      req_tdata <= {7'd0, os, iv, tm, cl};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_request(act, cl, tm, iv, os);
   endtask

   task automatic drain();
      @(posedge clock);
      req_tvalid <= 1'b0;
      wait (expected_results.size() == 0);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_tick_length(logic [9:0] v);
      drain();
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      tick_len = v;
   endtask

   task automatic test_directed();
      send_request(kstb_pkg::ACT_TICK, 16'h0, 16'h0, 32'h0, 1'b0);
      send_request(kstb_pkg::ACT_SET, 16'h0000, 16'h0000, 32'h0, 1'b0);
      send_request(kstb_pkg::ACT_SET, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1);
      send_request(kstb_pkg::ACT_SET, 16'h0001, 16'h0002, 32'd20, 1'b1);
      send_request(kstb_pkg::ACT_TICK, 16'h0, 16'h0, 32'h0, 1'b0);
      send_request(kstb_pkg::ACT_TICK, 16'h0, 16'h0, 32'h0, 1'b0);
      send_request(kstb_pkg::ACT_SET, 16'h0000, 16'h0000, 32'd30, 1'b0);
      send_request(kstb_pkg::ACT_KILL, 16'h1234, 16'h5678, 32'h0, 1'b0);
      send_request(kstb_pkg::ACT_CLIENT, 16'hABCD, 16'h0, 32'h0, 1'b0);
      send_request(kstb_pkg::ACT_SET, 16'h0002, 16'h0001, 32'd0, 1'b0);
      send_request(kstb_pkg::ACT_KILL, 16'h0002, 16'h0001, 32'h0, 1'b0);
      send_request(kstb_pkg::ACT_TICK, 16'h0, 16'h0, 32'h0, 1'b0);
      send_request(kstb_pkg::ACT_CLIENT, 16'hFFFF, 16'hFFFF, 32'h0, 1'b1);
      send_request(kstb_pkg::ACT_TICK, 16'h0, 16'h0, 32'h0, 1'b0);
      send_request(kstb_pkg::ACT_TICK, 16'h0, 16'h0, 32'h0, 1'b0);
      send_request(kstb_pkg::ACT_KILL, 16'h0000, 16'h0000, 32'h0, 1'b0);
      send_request(kstb_pkg::ACT_TICK, 16'h0, 16'h0, 32'h0, 1'b0);
   endtask

   task automatic test_full_table();
      for (int i = 0; i <= Slots; i++)
         send_request(kstb_pkg::ACT_SET, 16'h0100, 16'(Slots - i), 32'd0, 1'b0);
      send_request(kstb_pkg::ACT_TICK, 16'h0, 16'h0, 32'h0, 1'b0);
      send_request(kstb_pkg::ACT_CLIENT, 16'h0100, 16'h0, 32'h0, 1'b0);
      send_request(kstb_pkg::ACT_TICK, 16'h0, 16'h0, 32'h0, 1'b0);
   endtask

   task automatic random_requests(int count);
      logic [1:0]  act;
      logic [15:0] cl;
      logic [15:0] tm;
      logic [31:0] iv;
      int          r;
      for (int n = 0; n < count; n++) begin
         r = $urandom_range(99);
         act = r < 30 ? kstb_pkg::ACT_TICK : r < 70 ? kstb_pkg::ACT_SET :
               r < 85 ? kstb_pkg::ACT_KILL : kstb_pkg::ACT_CLIENT;
         if ($urandom_range(9) == 0) begin
            cl = 16'($urandom); tm = 16'($urandom);
         end else begin
            cl = 16'($urandom_range(3)); tm = 16'($urandom_range(7));
         end
         iv = $urandom_range(9) == 0 ? $urandom : $urandom_range(5) * tick_len;
         send_request(act, cl, tm, iv, 1'($urandom));
      end
   endtask

   task automatic test_backpressure();
      drain();
      recv_hold = 400;
      random_requests(12);
      drain();
   endtask

   initial begin
      tick_len = kstb_pkg::TickLenReset;
      for (int i = 0; i < Slots; i++) begin
         live[i] = 1'b0; doomed[i] = 1'b0; halted[i] = 1'b0;
      end
      send_idle_pct = 35;
      recv_idle_pct = 69;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      write_tick_length(10'd1);
      test_full_table();
      write_tick_length(10'd1000);
      test_directed();
      write_tick_length(10'd7);
      random_requests(60);
      send_idle_pct = 69;
      recv_idle_pct = 35;
      write_tick_length(10'd1);
      random_requests(60);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_tick_length(10'(300 + $urandom_range(700)));
      random_requests(60);
      test_backpressure();
      drain();
      repeat (100) @(posedge clock);
      if (errors == 0 && expected_results.size() == 0) begin
         $display("keyed_software_timer_bank_test OK");
      end else begin
         $display("keyed_software_timer_bank_test NOT OK");
      end
      $finish;
   end

endmodule

/* sim.f */
rtl/kstb_pkg.sv
rtl/kstb_datapath.sv
rtl/kstb_controller.sv
rtl/keyed_software_timer_bank.sv
tb/keyed_software_timer_bank_test.sv
